>>> hw/rtl/msc_pkg.sv
`timescale 1ns / 1ps

package msc_pkg;

  localparam int ModP       = 137;
  localparam int Axes       = 26;
  localparam int Ring       = 136;
  localparam int K42        = 42;
  localparam int LaneStep   = 7;
  localparam int LaneAdd    = 5;
  localparam int KeyBytes   = 26;
  localparam int Lanes      = 2;

  // floor(2^19 / 136); the estimate is low by at most one quotient step
  localparam int RecipMul   = 3855;
  localparam int RecipShift = 19;

  localparam int AxisW      = 5;
  localparam int PosW       = 8;
  localparam int XW         = 12;
  localparam int QW         = 5;
  localparam int SkW        = 9;
  localparam int DataW      = 64;
  localparam int AddrW      = 5;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] RegKey0  = 2'd0;
  localparam logic [1:0] RegKey1  = 2'd1;
  localparam logic [1:0] RegKey2  = 2'd2;
  localparam logic [1:0] RegKey3  = 2'd3;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  localparam logic [1:0] DTAB [Axes] = '{
    2'd0, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd1,
    2'd0, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd0, 2'd1, 2'd2, 2'd1, 2'd1
  };

  typedef logic [255:0][7:0] inv_rom_t;

  function automatic inv_rom_t build_inv_rom();
    inv_rom_t rom;
    rom = '0;
    for (int a = 1; a < ModP; a++) begin
      for (int c = 1; c < ModP; c++) begin
        if (((a * c) % ModP) == 1) begin
          rom[a] = 8'(c);
        end
      end
    end
    return rom;
  endfunction

  localparam inv_rom_t INV_ROM = build_inv_rom();

  typedef logic [KeyBytes-1:0][7:0] key_t;

  // classified word handed from the front to the back
  typedef struct packed {
    logic                         func;
    logic [7:0]                   a;
    logic [7:0]                   b;
    logic [Lanes-1:0][AxisW-1:0]  axis;
    logic [Lanes-1:0][XW-1:0]     x;
  } job_t;

endpackage

>>> hw/rtl/msc_ifs.sv
`timescale 1ns / 1ps

interface msc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic       first;
  logic [7:0] plain_in;
  logic [7:0] cipher_low_in;
  logic [7:0] cipher_high_in;

  modport source (output valid, func, first, plain_in, cipher_low_in, cipher_high_in,
                  input ready);
  modport sink   (input valid, func, first, plain_in, cipher_low_in, cipher_high_in,
                  output ready);
endinterface

interface msc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_low_out;
  logic [7:0] cipher_high_out;
  logic [7:0] plain_out;

  modport source (output valid, cipher_low_out, cipher_high_out, plain_out, input ready);
  modport sink   (input valid, cipher_low_out, cipher_high_out, plain_out, output ready);
endinterface

>>> hw/rtl/msc_cfg.sv
`timescale 1ns / 1ps

module msc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [msc_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [msc_pkg::DataW-1:0]   cfg_pwdata,
  output logic [msc_pkg::DataW-1:0]   cfg_prdata,
  output logic                        cfg_pready,
  output msc_pkg::key_t               key
);

  logic [63:0] key0_r;
  logic [63:0] key1_r;
  logic [63:0] key2_r;
  logic [15:0] key3_r;
  logic        wr_en;
  logic [1:0]  reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        msc_pkg::RegKey0: key0_r <= cfg_pwdata;
        msc_pkg::RegKey1: key1_r <= cfg_pwdata;
        msc_pkg::RegKey2: key2_r <= cfg_pwdata;
        msc_pkg::RegKey3: key3_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      msc_pkg::RegKey0: cfg_prdata = key0_r;
      msc_pkg::RegKey1: cfg_prdata = key1_r;
      msc_pkg::RegKey2: cfg_prdata = key2_r;
      msc_pkg::RegKey3: cfg_prdata = {48'd0, key3_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign key = {key3_r, key2_r, key1_r, key0_r};

endmodule

>>> hw/rtl/msc_front.sv
`timescale 1ns / 1ps

module msc_front (
  input  logic             clk,
  input  logic             rst_n,
  msc_in_if.sink           in_ch,
  input  logic             full,
  output logic             push,
  output msc_pkg::job_t    job
);

  logic [msc_pkg::AxisW-1:0] p26_r;
  logic [msc_pkg::AxisW-1:0] p26_nxt;
  logic [msc_pkg::PosW-1:0]  p1_r;
  logic [msc_pkg::PosW-1:0]  p1_nxt;
  logic [msc_pkg::AxisW-1:0] p26;
  logic [msc_pkg::PosW-1:0]  p1;
  logic [msc_pkg::AxisW:0]   axis_sum [msc_pkg::Lanes];

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  // first word of a message starts at axis position zero, ring position one
  assign p26 = in_ch.first ? '0 : p26_r;
  assign p1  = in_ch.first ? msc_pkg::PosW'(1) : p1_r;

  always_comb begin
    job.func = in_ch.func;
    job.a    = (in_ch.func == msc_pkg::OpDecrypt) ? in_ch.cipher_low_in : in_ch.plain_in;
    job.b    = in_ch.cipher_high_in;
    for (int l = 0; l < msc_pkg::Lanes; l++) begin
      axis_sum[l] = (msc_pkg::AxisW+1)'(p26) + (msc_pkg::AxisW+1)'(msc_pkg::LaneStep * l)
                  + (msc_pkg::AxisW+1)'(msc_pkg::DTAB[p26]);
      job.axis[l] = (axis_sum[l] >= (msc_pkg::AxisW+1)'(msc_pkg::Axes))
                  ? msc_pkg::AxisW'(axis_sum[l] - (msc_pkg::AxisW+1)'(msc_pkg::Axes))
                  : msc_pkg::AxisW'(axis_sum[l]);
      job.x[l]    = msc_pkg::XW'(p1) * msc_pkg::XW'(job.axis[l] + msc_pkg::AxisW'(1))
                  + msc_pkg::XW'(msc_pkg::K42 * l);
    end
  end

  assign p26_nxt = (p26 == msc_pkg::AxisW'(msc_pkg::Axes - 1)) ? '0 : p26 + msc_pkg::AxisW'(1);
  assign p1_nxt  = (p1 == msc_pkg::PosW'(msc_pkg::Ring - 1)) ? '0 : p1 + msc_pkg::PosW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p26_r <= '0;
      p1_r  <= msc_pkg::PosW'(1);
    end else if (push) begin
      p26_r <= p26_nxt;
      p1_r  <= p1_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (p26_r < msc_pkg::AxisW'(msc_pkg::Axes)) && (p1_r < msc_pkg::PosW'(msc_pkg::Ring)))
    else $error("position counters out of range");

  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_ch.first |=> (p26_r == msc_pkg::AxisW'(1)) && (p1_r == msc_pkg::PosW'(2)))
    else $error("first word did not restart position");

endmodule

>>> hw/rtl/msc_queue.sv
`timescale 1ns / 1ps

module msc_queue #(
  parameter int DEPTH = msc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  msc_pkg::job_t    push_job,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output msc_pkg::job_t    head_job
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  msc_pkg::job_t   mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;

  assign full       = (cnt_r == CntW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

>>> hw/rtl/msc_back.sv
`timescale 1ns / 1ps

module msc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  msc_pkg::key_t    key,
  input  logic             job_valid,
  input  msc_pkg::job_t    job,
  output logic             pop,
  msc_out_if.source        out_ch
);

  typedef struct packed {
    logic                                         func;
    logic [7:0]                                   a;
    logic [7:0]                                   b;
    logic [msc_pkg::Lanes-1:0][msc_pkg::XW-1:0]   x;
    logic [msc_pkg::Lanes-1:0][msc_pkg::QW-1:0]   q;
    logic [msc_pkg::Lanes-1:0][msc_pkg::SkW-1:0]  sk;
  } s2_t;

  typedef struct packed {
    logic                           func;
    logic [7:0]                     a;
    logic [7:0]                     b;
    logic [msc_pkg::Lanes-1:0][7:0] m;
  } s3_t;

  logic          s1_v_r;
  msc_pkg::job_t s1_r;
  logic          s2_v_r;
  s2_t           s2_r;
  s2_t           s2_nxt;
  logic          s3_v_r;
  s3_t           s3_r;
  s3_t           s3_nxt;
  logic          out_v_r;
  logic [7:0]    cl_r;
  logic [7:0]    ch_r;
  logic [7:0]    pl_r;
  logic [7:0]    cl_nxt;
  logic [7:0]    ch_nxt;
  logic [7:0]    pl_nxt;

  logic adv_out;
  logic adv3;
  logic adv2;
  logic adv1;

  logic [23:0]              prod  [msc_pkg::Lanes];
  logic [msc_pkg::XW-1:0]   qmul  [msc_pkg::Lanes];
  logic [msc_pkg::XW-1:0]   rem_w [msc_pkg::Lanes];
  logic [8:0]               rem   [msc_pkg::Lanes];
  logic [7:0]               r_idx [msc_pkg::Lanes];
  logic [9:0]               msum  [msc_pkg::Lanes];

  logic [7:0] e_lo;
  logic [7:0] e_hi;
  logic [8:0] e_sl;
  logic [8:0] e_sh;
  logic [9:0] d_t0;
  logic [9:0] d_t1;
  logic [7:0] d_lo;
  logic [7:0] d_hi;

  // each stage moves when the one after it is empty or moving
  assign adv_out = !out_v_r || out_ch.ready;
  assign adv3    = !s3_v_r || adv_out;
  assign adv2    = !s2_v_r || adv3;
  assign adv1    = !s1_v_r || adv2;
  assign pop     = job_valid && adv1;

  // stage 1: quotient estimate of x / 136 and key-dependent part of the mask
  always_comb begin
    s2_nxt.func = s1_r.func;
    s2_nxt.a    = s1_r.a;
    s2_nxt.b    = s1_r.b;
    s2_nxt.x    = s1_r.x;
    for (int l = 0; l < msc_pkg::Lanes; l++) begin
      prod[l]      = 24'(s1_r.x[l]) * 24'(msc_pkg::RecipMul);
      s2_nxt.q[l]  = prod[l][msc_pkg::RecipShift +: msc_pkg::QW];
      s2_nxt.sk[l] = msc_pkg::SkW'(key[s1_r.axis[l]])
                   + msc_pkg::SkW'(msc_pkg::K42 * msc_pkg::DTAB[s1_r.axis[l]])
                   + msc_pkg::SkW'(s1_r.axis[l])
                   + msc_pkg::SkW'(msc_pkg::LaneAdd * l);
    end
  end

  // stage 2: finish mod 136, look up the inverse, reduce the mask mod 137
  always_comb begin
    s3_nxt.func = s2_r.func;
    s3_nxt.a    = s2_r.a;
    s3_nxt.b    = s2_r.b;
    for (int l = 0; l < msc_pkg::Lanes; l++) begin
      qmul[l]  = (msc_pkg::XW'(s2_r.q[l]) << 7) + (msc_pkg::XW'(s2_r.q[l]) << 3);
      rem_w[l] = s2_r.x[l] - qmul[l];
      rem[l]   = rem_w[l][8:0];
      if (rem[l] >= 9'(msc_pkg::Ring)) begin
        rem[l] = rem[l] - 9'(msc_pkg::Ring);
      end
      r_idx[l] = 8'(rem[l]) + 8'd1;
      msum[l]  = 10'(s2_r.sk[l]) + 10'(msc_pkg::INV_ROM[r_idx[l]]);
      priority if (msum[l] >= 10'(3 * msc_pkg::ModP)) begin
        s3_nxt.m[l] = 8'(msum[l] - 10'(3 * msc_pkg::ModP));
      end else if (msum[l] >= 10'(2 * msc_pkg::ModP)) begin
        s3_nxt.m[l] = 8'(msum[l] - 10'(2 * msc_pkg::ModP));
      end else if (msum[l] >= 10'(msc_pkg::ModP)) begin
        s3_nxt.m[l] = 8'(msum[l] - 10'(msc_pkg::ModP));
      end else begin
        s3_nxt.m[l] = 8'(msum[l]);
      end
    end
  end

  // stage 3: apply the masks
  always_comb begin
    e_lo = (s3_r.a >= 8'(msc_pkg::ModP)) ? s3_r.a - 8'(msc_pkg::ModP) : s3_r.a;
    e_hi = (s3_r.a >= 8'(msc_pkg::ModP)) ? 8'd1 : 8'd0;
    e_sl = 9'(e_lo) + 9'(s3_r.m[0]);
    e_sh = 9'(e_hi) + 9'(s3_r.m[1]);
    d_t0 = 10'(s3_r.a) + 10'(msc_pkg::ModP) - 10'(s3_r.m[0]);
    d_t1 = 10'(s3_r.b) + 10'(msc_pkg::ModP) - 10'(s3_r.m[1]);
    priority if (d_t0 >= 10'(2 * msc_pkg::ModP)) begin
      d_lo = 8'(d_t0 - 10'(2 * msc_pkg::ModP));
    end else if (d_t0 >= 10'(msc_pkg::ModP)) begin
      d_lo = 8'(d_t0 - 10'(msc_pkg::ModP));
    end else begin
      d_lo = 8'(d_t0);
    end
    priority if (d_t1 >= 10'(2 * msc_pkg::ModP)) begin
      d_hi = 8'(d_t1 - 10'(2 * msc_pkg::ModP));
    end else if (d_t1 >= 10'(msc_pkg::ModP)) begin
      d_hi = 8'(d_t1 - 10'(msc_pkg::ModP));
    end else begin
      d_hi = 8'(d_t1);
    end
    if (s3_r.func == msc_pkg::OpDecrypt) begin
      cl_nxt = '0;
      ch_nxt = '0;
      pl_nxt = d_lo + 8'(16'(d_hi) * 16'(msc_pkg::ModP));
    end else begin
      cl_nxt = (e_sl >= 9'(msc_pkg::ModP)) ? 8'(e_sl - 9'(msc_pkg::ModP)) : 8'(e_sl);
      ch_nxt = (e_sh >= 9'(msc_pkg::ModP)) ? 8'(e_sh - 9'(msc_pkg::ModP)) : 8'(e_sh);
      pl_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_r <= job_valid;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv3) begin
        s3_v_r <= s2_v_r;
      end
      if (adv_out) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_r <= job;
    end
    if (adv2) begin
      s2_r <= s2_nxt;
    end
    if (adv3) begin
      s3_r <= s3_nxt;
    end
    if (adv_out) begin
      cl_r <= cl_nxt;
      ch_r <= ch_nxt;
      pl_r <= pl_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.cipher_low_out  = cl_r;
  assign out_ch.cipher_high_out = ch_r;
  assign out_ch.plain_out       = pl_r;

  a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (s3_r.m[0] < 8'(msc_pkg::ModP)) && (s3_r.m[1] < 8'(msc_pkg::ModP)))
    else $error("mask not reduced mod 137");

endmodule

>>> hw/rtl/mod137_stream_cipher.sv
`timescale 1ns / 1ps

// channel | dir  | handshake          | payload
// in_ch   | in   | valid / ready      | func, first, plain_in, cipher_low_in, cipher_high_in
// out_ch  | out  | valid / ready      | cipher_low_out, cipher_high_out, plain_out
// cfg_*   | in   | APB psel / penable | key registers at byte addresses 0, 8, 16, 24
//
// One word accepted per cycle and one result per cycle while nothing stalls; a result
// passes the queue, then the s1, s2 and s3 stage registers and the output register.
// The front advances the position counters and computes lane axes and the ring
// product, reduced mod 136 in the back; a QUEUE_DEPTH-entry queue sits between them.
// in_ch.ready drops only when the queue is full; out_ch stalls ripple back to the queue.
// Synchronous active-low reset clears the key registers and sets axis 0, ring position 1.

module mod137_stream_cipher #(
  parameter int QUEUE_DEPTH = msc_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  msc_in_if.sink                      in_ch,
  msc_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [msc_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [msc_pkg::DataW-1:0]   cfg_pwdata,
  output logic [msc_pkg::DataW-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  msc_pkg::key_t key;
  msc_pkg::job_t push_job;
  msc_pkg::job_t head_job;
  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;

  msc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .key         (key)
  );

  msc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .job   (push_job)
  );

  msc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  msc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (key),
    .job_valid (head_valid),
    .job       (head_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

>>> bench/mod137_stream_cipher_tb.sv
`timescale 1ns / 1ps

module mod137_stream_cipher_tb;

  localparam int Prime     = 137;
  localparam int AxisCount = 26;
  localparam int RingSize  = 136;
  localparam int RingStep  = 42;
  localparam int LaneShift = 7;
  localparam int LaneBias  = 5;

  localparam int AxisSkew [AxisCount] = '{
    0, 2, 1, 0, 1, 0, 2, 0, 0, 1, 2, 1, 1,
    0, 2, 1, 0, 1, 0, 2, 0, 0, 1, 2, 1, 1
  };

  typedef struct packed {
    logic       func;
    logic       first;
    logic [7:0] plain;
    logic [7:0] cipher_low;
    logic [7:0] cipher_high;
  } word_t;

  typedef struct packed {
    logic [7:0] cipher_low;
    logic [7:0] cipher_high;
    logic [7:0] plain;
  } cipher_result_t;

  typedef struct packed {
    word_t          stim;
    logic           typed;
    cipher_result_t want;
  } dir_row_t;

  localparam int DirRows = 20;

  // typed rows hold with an all-zero key only
  localparam dir_row_t DIR_TABLE [DirRows] = '{
    '{'{msc_pkg::OpEncrypt, 1'b0, 8'd0,   8'd0,   8'd0},   1'b1, '{8'd69, 8'd55, 8'd0}},
    '{'{msc_pkg::OpEncrypt, 1'b1, 8'd255, 8'd0,   8'd0},   1'b1, '{8'd50, 8'd56, 8'd0}},
    '{'{msc_pkg::OpDecrypt, 1'b1, 8'd0,   8'd69,  8'd55},  1'b1, '{8'd0,  8'd0,  8'd0}},
    '{'{msc_pkg::OpDecrypt, 1'b1, 8'd0,   8'd50,  8'd56},  1'b1, '{8'd0,  8'd0,  8'd255}},
    '{'{msc_pkg::OpDecrypt, 1'b1, 8'd0,   8'd255, 8'd255}, 1'b1, '{8'd0,  8'd0,  8'd232}},
    '{'{msc_pkg::OpEncrypt, 1'b0, 8'd136, 8'd0,   8'd0},   1'b0, '0},
    '{'{msc_pkg::OpEncrypt, 1'b0, 8'd137, 8'd0,   8'd0},   1'b0, '0},
    '{'{msc_pkg::OpDecrypt, 1'b0, 8'd0,   8'd136, 8'd136}, 1'b0, '0},
    '{'{msc_pkg::OpDecrypt, 1'b0, 8'd0,   8'd137, 8'd137}, 1'b0, '0},
    '{'{msc_pkg::OpDecrypt, 1'b0, 8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{'{msc_pkg::OpEncrypt, 1'b0, 8'd85,  8'd0,   8'd0},   1'b0, '0},
    '{'{msc_pkg::OpEncrypt, 1'b0, 8'd170, 8'd0,   8'd0},   1'b0, '0},
    '{'{msc_pkg::OpDecrypt, 1'b0, 8'd0,   8'd85,  8'd170}, 1'b0, '0},
    '{'{msc_pkg::OpDecrypt, 1'b0, 8'd0,   8'd170, 8'd85},  1'b0, '0},
    '{'{msc_pkg::OpEncrypt, 1'b1, 8'd1,   8'd0,   8'd0},   1'b1, '{8'd70, 8'd55, 8'd0}},
    '{'{msc_pkg::OpEncrypt, 1'b0, 8'd128, 8'd0,   8'd0},   1'b0, '0},
    '{'{msc_pkg::OpDecrypt, 1'b1, 8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{'{msc_pkg::OpEncrypt, 1'b0, 8'd127, 8'd0,   8'd0},   1'b0, '0},
    '{'{msc_pkg::OpDecrypt, 1'b0, 8'd0,   8'd1,   8'd128}, 1'b0, '0},
    '{'{msc_pkg::OpEncrypt, 1'b0, 8'd255, 8'd0,   8'd0},   1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                      cfg_psel;
  logic                      cfg_penable;
  logic                      cfg_pwrite;
  logic [msc_pkg::AddrW-1:0] cfg_paddr;
  logic [msc_pkg::DataW-1:0] cfg_pwdata;
  logic [msc_pkg::DataW-1:0] cfg_prdata;
  logic                      cfg_pready;

  msc_in_if  in_ch();
  msc_out_if out_ch();

  mod137_stream_cipher DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] key_reg [4];
  logic [4:0]  pos_axis;
  logic [7:0]  pos_ring;
  int          inv_tab [Prime];

  cipher_result_t pending_results [$];
  int             mismatch_count = 0;
  bit             idle_en = 1'b1;
  bit             stall_en = 1'b1;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("tb: mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic int lane_mask(input int p26, input int p1, input int lane);
    int axis;
    int r;
    int sum;
    axis = (p26 + LaneShift * lane + AxisSkew[p26]) % AxisCount;
    r = ((p1 * (axis + 1) + RingStep * lane) % RingSize) + 1;
    sum = key_reg[axis / 8][8 * (axis % 8) +: 8] + RingStep * AxisSkew[axis] + inv_tab[r]
        + LaneBias * lane + axis;
    return sum % Prime;
  endfunction

  task automatic advance_cipher(input word_t w, output cipher_result_t r);
    int p26;
    int p1;
    int m0;
    int m1;
    int lo;
    int hi;
    p26 = w.first ? 0 : int'(pos_axis);
    p1 = w.first ? 1 : int'(pos_ring);
    m0 = lane_mask(p26, p1, 0);
    m1 = lane_mask(p26, p1, 1);
    r = '0;
    if (w.func == msc_pkg::OpEncrypt) begin
      r.cipher_low = 8'((int'(w.plain) % Prime + m0) % Prime);
      r.cipher_high = 8'((int'(w.plain) / Prime + m1) % Prime);
    end else begin
      lo = (int'(w.cipher_low) + Prime - m0) % Prime;
      hi = (int'(w.cipher_high) + Prime - m1) % Prime;
      r.plain = 8'(lo + hi * Prime);
    end
    pos_axis = 5'((p26 + 1) % AxisCount);
    pos_ring = 8'((p1 + 1) % RingSize);
  endtask

  // enter and leave at a falling edge
  task automatic send_word(input word_t w, input logic typed, input cipher_result_t want,
                           output cipher_result_t res);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 99) >= 55) gap = stall_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= w.func;
    in_ch.first          <= w.first;
    in_ch.plain_in       <= w.plain;
    in_ch.cipher_low_in  <= w.cipher_low;
    in_ch.cipher_high_in <= w.cipher_high;
    do @(posedge clk); while (!in_ch.ready);
    advance_cipher(w, res);
    pending_results.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic write_key_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    key_reg[idx] = (idx == msc_pkg::RegKey3) ? {48'd0, value[15:0]} : value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_traffic(input int budget, input int long_len, input bit pause_mid);
    cipher_result_t res;
    cipher_result_t sealed [$];
    word_t          w;
    int             sent;
    int             kind;
    int             len;
    bit             paused;
    sent = 0;
    paused = 1'b0;
    // one long message so both position counters wrap
    for (int i = 0; i < long_len; i++) begin
      w = '{msc_pkg::OpEncrypt, (i == 0), 8'($urandom), 8'($urandom), 8'($urandom)};
      send_word(w, 1'b0, '0, res);
    end
    while (sent < budget) begin
      if (pause_mid && !paused && sent >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 50) : $urandom_range(1, 16);
      if (kind < 45) begin
        sealed.delete();
        for (int i = 0; i < len; i++) begin
          w = '{msc_pkg::OpEncrypt, (i == 0), 8'($urandom), 8'($urandom), 8'($urandom)};
          send_word(w, 1'b0, '0, res);
          sealed.push_back(res);
        end
        // replay as decrypt; damage a symbol now and then
        for (int i = 0; i < len; i++) begin
          w = '{msc_pkg::OpDecrypt, (i == 0), 8'($urandom), sealed[i].cipher_low,
                sealed[i].cipher_high};
          if ($urandom_range(0, 11) == 0) w.cipher_low = 8'($urandom);
          if ($urandom_range(0, 11) == 0) w.cipher_high = 8'($urandom);
          send_word(w, 1'b0, '0, res);
        end
        sent += 2 * len;
      end else if (kind < 65) begin
        for (int i = 0; i < len; i++) begin
          w = '{1'($urandom), (i == 0), 8'($urandom), 8'($urandom_range(0, Prime - 1)),
                8'($urandom_range(0, Prime - 1))};
          send_word(w, 1'b0, '0, res);
        end
        sent += len;
      end else if (kind < 80) begin
        for (int i = 0; i < len; i++) begin
          w = '{1'($urandom), ($urandom_range(0, 7) == 0), 8'($urandom), 8'($urandom),
                8'($urandom)};
          send_word(w, 1'b0, '0, res);
        end
        sent += len;
      end else begin
        for (int i = 0; i < len; i++) begin
          w = '{msc_pkg::OpDecrypt, (i == 0), 8'($urandom), 8'($urandom), 8'($urandom)};
          send_word(w, 1'b0, '0, res);
        end
        sent += len;
      end
    end
  endtask

  initial begin : result_ready
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!stall_en || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        hold = $urandom_range(0, 8);
      end else begin
        out_ch.ready <= 1'b0;
        hold = stall_len() - 1;
      end
    end
  end

  always @(posedge clk) begin
    cipher_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result low %0d high %0d plain %0d",
                                  out_ch.cipher_low_out, out_ch.cipher_high_out,
                                  out_ch.plain_out));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.cipher_low_out !== want.cipher_low)
          report_mismatch($sformatf("cipher_low_out got %0d want %0d",
                                    out_ch.cipher_low_out, want.cipher_low));
        if (out_ch.cipher_high_out !== want.cipher_high)
          report_mismatch($sformatf("cipher_high_out got %0d want %0d",
                                    out_ch.cipher_high_out, want.cipher_high));
        if (out_ch.plain_out !== want.plain)
          report_mismatch($sformatf("plain_out got %0d want %0d",
                                    out_ch.plain_out, want.plain));
      end
    end
  end

  initial begin : stimulus
    cipher_result_t res;
    logic [63:0]    value;
    int             spins;
    for (int a = 1; a < Prime; a++) begin
      inv_tab[a] = 1;
      repeat (Prime - 2) inv_tab[a] = (inv_tab[a] * a) % Prime;
    end
    inv_tab[0] = 0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    pos_axis = '0;
    pos_ring = 8'd1;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.func           = msc_pkg::OpEncrypt;
    in_ch.first          = 1'b0;
    in_ch.plain_in       = '0;
    in_ch.cipher_low_in  = '0;
    in_ch.cipher_high_in = '0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // first word runs on the reset position, before any register write
    send_word(DIR_TABLE[0].stim, DIR_TABLE[0].typed, DIR_TABLE[0].want, res);
    wait_drained();
    @(negedge clk);
    write_key_reg(msc_pkg::RegKey0, '0);
    write_key_reg(msc_pkg::RegKey1, '0);
    write_key_reg(msc_pkg::RegKey2, '0);
    write_key_reg(msc_pkg::RegKey3, '0);
    for (int i = 1; i < DirRows; i++)
      send_word(DIR_TABLE[i].stim, DIR_TABLE[i].typed, DIR_TABLE[i].want, res);
    run_traffic(40, 0, 1'b0);
    wait_drained();
    @(negedge clk);

    for (int phase = 1; phase <= 5; phase++) begin
      for (int r = 0; r < 4; r++) begin
        case (phase)
          1: value = '1;
          4: value = (r % 2 == 0) ? 64'h00FF_00FF_00FF_00FF : 64'h8888_8888_8888_8888;
          default: value = {$urandom, $urandom};
        endcase
        write_key_reg(2'(r), value);
      end
      idle_en = (phase != 4);
      stall_en = (phase != 4);
      run_traffic(45, (phase == 2) ? 160 : 0, phase == 3);
      wait_drained();
      @(negedge clk);
    end
    idle_en = 1'b1;
    stall_en = 1'b1;

    in_ch.valid <= 1'b0;
    spins = 0;
    while (pending_results.size() != 0 && spins < 5000) begin
      @(negedge clk);
      spins++;
    end
    repeat (20) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/msc_pkg.sv
hw/rtl/msc_ifs.sv
hw/rtl/msc_cfg.sv
hw/rtl/msc_front.sv
hw/rtl/msc_queue.sv
hw/rtl/msc_back.sv
hw/rtl/mod137_stream_cipher.sv
bench/mod137_stream_cipher_tb.sv
